>>> rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  // Register widths
  localparam int unsigned PreW    = 8;
  localparam int unsigned HighW   = 8;
  localparam int unsigned TimeW   = 24;
  localparam int unsigned ScaleW  = 18;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned CfgIdxW = 3;

  // Result widths
  localparam int unsigned PulseW = 24;
  localparam int unsigned DistW  = 26;
  localparam int unsigned FracW  = 16;

  // Phase counter saturates at its full range
  localparam logic [TimeW-1:0] PhaseMax = '1;

  // Register reset values
  localparam logic [PreW-1:0]   PreRst   = 8'd2;
  localparam logic [HighW-1:0]  HighRst  = 8'd10;
  localparam logic [TimeW-1:0]  RiseRst  = 24'd1000000;
  localparam logic [TimeW-1:0]  FallRst  = 24'd1000000;
  localparam logic [ScaleW-1:0] ScaleRst = 18'd112394;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPreLow   = 3'd0,
    CfgTrigHigh = 3'd1,
    CfgRiseTo   = 3'd2,
    CfgFallTo   = 3'd3,
    CfgScale    = 3'd4
  } cfg_idx_e;

  // Measurement phase, one-hot
  typedef enum logic [4:0] {
    PhIdle     = 5'b00001,
    PhPreLow   = 5'b00010,
    PhTrigHigh = 5'b00100,
    PhWaitRise = 5'b01000,
    PhWaitFall = 5'b10000
  } phase_e;

  // Completion status
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StRiseTo   = 2'd1,
    StFallTo   = 2'd2,
    StReserved = 2'd3
  } status_e;

  // Configuration bundle
  typedef struct packed {
    logic [PreW-1:0]   pre_low;
    logic [HighW-1:0]  trig_high;
    logic [TimeW-1:0]  rise_to;
    logic [TimeW-1:0]  fall_to;
    logic [ScaleW-1:0] scale;
  } cfg_t;

  // Flags passed from the control stage to the output stage
  typedef struct packed {
    logic    trigger;
    logic    busy;
    logic    done;
    status_e status;
  } flags_t;

endpackage

`default_nettype wire

>>> rtl/uer_if.sv
// ----------------------------------------------------------------------------
// uer_in_if / uer_out_if
// Valid/ready channels carrying tick samples in and measurement results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, output start_req, output echo, input ready);
  modport sink   (input valid, input start_req, input echo, output ready);
endinterface

interface uer_out_if;
  logic                        valid;
  logic                        ready;
  logic                        trigger;
  logic                        busy_res;
  logic                        done_res;
  logic [1:0]                  status;
  logic [uer_pkg::PulseW-1:0]  pulse_ticks;
  logic [uer_pkg::DistW-1:0]   distance_centi_cm;

  modport source (output valid, output trigger, output busy_res, output done_res,
                  output status, output pulse_ticks, output distance_centi_cm,
                  input ready);
  modport sink   (input valid, input trigger, input busy_res, input done_res,
                  input status, input pulse_ticks, input distance_centi_cm,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/uer_cfg.sv
// ----------------------------------------------------------------------------
// uer_cfg
// Configuration register file with write-only access.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [uer_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [uer_pkg::CfgW-1:0]      cfg_wdata_i,
  output uer_pkg::cfg_t                      cfg_o
);

  uer_pkg::cfg_t cfg_q;

  // Write one register per transfer; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre_low   <= uer_pkg::PreRst;
      cfg_q.trig_high <= uer_pkg::HighRst;
      cfg_q.rise_to   <= uer_pkg::RiseRst;
      cfg_q.fall_to   <= uer_pkg::FallRst;
      cfg_q.scale     <= uer_pkg::ScaleRst;
    end else if (cfg_we_i) begin
      case (uer_pkg::cfg_idx_e'(cfg_idx_i))
        uer_pkg::CfgPreLow:   cfg_q.pre_low   <= cfg_wdata_i[uer_pkg::PreW-1:0];
        uer_pkg::CfgTrigHigh: cfg_q.trig_high <= cfg_wdata_i[uer_pkg::HighW-1:0];
        uer_pkg::CfgRiseTo:   cfg_q.rise_to   <= cfg_wdata_i[uer_pkg::TimeW-1:0];
        uer_pkg::CfgFallTo:   cfg_q.fall_to   <= cfg_wdata_i[uer_pkg::TimeW-1:0];
        uer_pkg::CfgScale:    cfg_q.scale     <= cfg_wdata_i[uer_pkg::ScaleW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// Trigger/echo sequencer: advances the measurement once per accepted tick and
// registers the per-tick flags and the finished pulse count.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_ctrl #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire uer_pkg::cfg_t          cfg_i,
  uer_in_if.sink                      in_i,
  output logic                        s1_valid_o,
  input  wire logic                   s1_ready_i,
  output uer_pkg::flags_t             s1_flags_o,
  output logic [COUNT_BITS-1:0]       s1_pulse_o
);

  localparam int unsigned TimeW = uer_pkg::TimeW;

  uer_pkg::phase_e        phase_q, phase_d;
  logic [TimeW-1:0]       phase_cnt_q, phase_cnt_d;
  logic [COUNT_BITS-1:0]  pulse_cnt_q, pulse_cnt_d;

  logic                   s1_valid_q;
  uer_pkg::flags_t        flags_q, flags_d;
  logic [COUNT_BITS-1:0]  res_pulse_q, res_pulse_d;

  logic                   accept;
  logic [TimeW-1:0]       high_len;

  function automatic logic [TimeW-1:0] bump(input logic [TimeW-1:0] c);
    return (c < uer_pkg::PhaseMax) ? c + TimeW'(1) : c;
  endfunction

  // Take a tick when the stage is empty or drains this cycle
  assign in_i.ready = !s1_valid_q || s1_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // A zero-length trigger pulse lasts one tick
  assign high_len = (cfg_i.trig_high == '0) ? TimeW'(1) : TimeW'(cfg_i.trig_high);

  // Walk the phases for one tick
  always_comb begin
    phase_d       = phase_q;
    phase_cnt_d   = phase_cnt_q;
    pulse_cnt_d   = pulse_cnt_q;
    flags_d       = '0;
    flags_d.status = uer_pkg::StOk;
    res_pulse_d   = '0;

    if (phase_q == uer_pkg::PhIdle && in_i.start_req) begin
      phase_d     = uer_pkg::PhPreLow;
      phase_cnt_d = '0;
      pulse_cnt_d = '0;
    end

    if (phase_d == uer_pkg::PhPreLow) begin
      if (phase_cnt_d >= TimeW'(cfg_i.pre_low)) begin
        phase_d     = uer_pkg::PhTrigHigh;
        phase_cnt_d = '0;
      end else begin
        phase_cnt_d = bump(phase_cnt_d);
      end
    end

    if (phase_d == uer_pkg::PhTrigHigh) begin
      if (phase_cnt_d >= high_len) begin
        phase_d     = uer_pkg::PhWaitRise;
        phase_cnt_d = '0;
      end else begin
        phase_cnt_d     = bump(phase_cnt_d);
        flags_d.trigger = 1'b1;
      end
    end

    if (phase_d == uer_pkg::PhWaitRise && !flags_d.trigger) begin
      if (in_i.echo) begin
        phase_d     = uer_pkg::PhWaitFall;
        phase_cnt_d = '0;
        pulse_cnt_d = COUNT_BITS'(1);
      end else begin
        phase_cnt_d = bump(phase_cnt_d);
        if (phase_cnt_d >= cfg_i.rise_to) begin
          phase_d        = uer_pkg::PhIdle;
          flags_d.done   = 1'b1;
          flags_d.status = uer_pkg::StRiseTo;
        end
      end
    end else if (phase_d == uer_pkg::PhWaitFall) begin
      if (in_i.echo) begin
        if (pulse_cnt_d != '1) begin
          pulse_cnt_d = pulse_cnt_d + COUNT_BITS'(1);
        end
        phase_cnt_d = bump(phase_cnt_d);
        if (phase_cnt_d >= cfg_i.fall_to) begin
          phase_d        = uer_pkg::PhIdle;
          flags_d.done   = 1'b1;
          flags_d.status = uer_pkg::StFallTo;
        end
      end else begin
        phase_d      = uer_pkg::PhIdle;
        flags_d.done = 1'b1;
        res_pulse_d  = pulse_cnt_d;
      end
    end

    flags_d.busy = (phase_d != uer_pkg::PhIdle);
  end

  // Advance the state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= uer_pkg::PhIdle;
      phase_cnt_q <= '0;
      pulse_cnt_q <= '0;
    end else if (accept) begin
      phase_q     <= phase_d;
      phase_cnt_q <= phase_cnt_d;
      pulse_cnt_q <= pulse_cnt_d;
    end
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q     <= flags_d;
      res_pulse_q <= res_pulse_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_flags_o = flags_q;
  assign s1_pulse_o = res_pulse_q;

endmodule

`default_nettype wire

>>> rtl/uer_dist.sv
// ----------------------------------------------------------------------------
// uer_dist
// Output stage: scales the pulse width into distance, saturates both results
// and holds them in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_dist #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire uer_pkg::cfg_t          cfg_i,
  input  wire logic                   s1_valid_i,
  output logic                        s1_ready_o,
  input  wire uer_pkg::flags_t        s1_flags_i,
  input  wire logic [COUNT_BITS-1:0]  s1_pulse_i,
  uer_out_if.source                   out_o
);

  localparam int unsigned ProdW  = COUNT_BITS + uer_pkg::ScaleW;
  localparam int unsigned PulseW = uer_pkg::PulseW;
  localparam int unsigned DistW  = uer_pkg::DistW;

  logic                  out_valid_q;
  uer_pkg::flags_t       flags_q;
  logic [PulseW-1:0]     pulse_q, pulse_d;
  logic [DistW-1:0]      dist_q, dist_d;
  logic [ProdW-1:0]      prod;
  logic [ProdW-1:0]      prod_sh;
  logic                  load;

  // Refill the output register when empty or when the sink takes it
  assign load       = !out_valid_q || out_o.ready;
  assign s1_ready_o = load;

  // Scale, drop the fraction and clamp
  always_comb begin
    prod    = ProdW'(s1_pulse_i) * ProdW'(cfg_i.scale);
    prod_sh = prod >> uer_pkg::FracW;
    dist_d  = (64'(prod_sh) > 64'({DistW{1'b1}})) ? '1 : DistW'(prod_sh);
    pulse_d = (32'(s1_pulse_i) > 32'({PulseW{1'b1}})) ? '1 : PulseW'(s1_pulse_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && s1_valid_i) begin
      flags_q <= s1_flags_i;
      pulse_q <= pulse_d;
      dist_q  <= dist_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.trigger           = flags_q.trigger;
  assign out_o.busy_res          = flags_q.busy;
  assign out_o.done_res          = flags_q.done;
  assign out_o.status            = flags_q.status;
  assign out_o.pulse_ticks       = pulse_q;
  assign out_o.distance_centi_cm = dist_q;

endmodule

`default_nettype wire

>>> rtl/ultrasonic_echo_ranger_top.sv
// Throughput: one tick per cycle while the output is not stalled; the sequencer
// register and the output register form a two-stage pipeline with the multiplier
// in the second stage.
// Reset: rst_ni clears the sequencer to idle, empties both stages and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_top
// Trigger/echo ranging controller stepped once per microsecond tick.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger_top #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [uer_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [uer_pkg::CfgW-1:0]      cfg_wdata_i,
  uer_in_if.sink                             in_i,
  uer_out_if.source                          out_o
);

  uer_pkg::cfg_t          cfg;
  logic                   s1_valid;
  logic                   s1_ready;
  uer_pkg::flags_t        s1_flags;
  logic [COUNT_BITS-1:0]  s1_pulse;

  // Registers
  uer_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequencer stage
  uer_ctrl #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_i       (in_i),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_flags_o (s1_flags),
    .s1_pulse_o (s1_pulse)
  );

  // Distance and output stage
  uer_dist #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_flags_i (s1_flags),
    .s1_pulse_i (s1_pulse),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

>>> verif/tb_ultrasonic_echo_ranger_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger_top
// Self-checking bench for the trigger/echo ranging controller. Ticks are sent
// as trigger/echo measurement sequences with random content, plus noise ticks.
// A tick-exact software copy of the sequencer predicts every reading, and a
// monitor compares each reading transfer with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_ultrasonic_echo_ranger_top;

  localparam int unsigned ClkPeriod      = 4;
  localparam int unsigned CountBits      = 24;
  localparam int unsigned HoldCycles     = 300;
  localparam int unsigned RandomTicks    = 240;
  localparam int unsigned RandomSettings = 4;
  localparam int unsigned WatchdogNs     = 20_000_000;

  // One reading as the block reports it for a tick
  typedef struct packed {
    logic                       trigger;
    logic                       busy;
    logic                       done;
    uer_pkg::status_e           status;
    logic [uer_pkg::PulseW-1:0] pulse;
    logic [uer_pkg::DistW-1:0]  distance;
  } reading_t;

  logic                     clk_i  = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we;
  uer_pkg::cfg_idx_e        cfg_idx;
  logic [uer_pkg::CfgW-1:0] cfg_wdata;

  uer_in_if  tick_if ();
  uer_out_if reading_if ();

  ultrasonic_echo_ranger_top #(
    .COUNT_BITS (CountBits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (tick_if),
    .out_o       (reading_if)
  );

  // Sequencer copy, kept in step with the accepted ticks
  uer_pkg::cfg_t             ranger_cfg;
  uer_pkg::phase_e           ranger_phase;
  logic [uer_pkg::TimeW-1:0] phase_cnt;
  logic [CountBits-1:0]      echo_cnt;

  reading_t    pending_readings[$];
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  bit          idling_on  = 1'b0;
  bit          hold_req   = 1'b0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [uer_pkg::TimeW-1:0] bump(input logic [uer_pkg::TimeW-1:0] c);
    return (c == uer_pkg::PhaseMax) ? c : c + 1'b1;
  endfunction

  // Advance the sequencer copy by one tick and return the reading it produces
  function automatic reading_t ranger_step(input logic start_req, input logic echo);
    reading_t                                r;
    logic [uer_pkg::HighW-1:0]               trig_len;
    logic [CountBits+uer_pkg::ScaleW-1:0]    product;
    logic [CountBits+uer_pkg::ScaleW-1:0]    dist_full;
    r        = '0;
    trig_len = (ranger_cfg.trig_high == '0) ? 8'd1 : ranger_cfg.trig_high;

    if (ranger_phase == uer_pkg::PhIdle && start_req) begin
      ranger_phase = uer_pkg::PhPreLow;
      phase_cnt    = '0;
      echo_cnt     = '0;
    end
    if (ranger_phase == uer_pkg::PhPreLow) begin
      if (phase_cnt >= ranger_cfg.pre_low) begin
        ranger_phase = uer_pkg::PhTrigHigh;
        phase_cnt    = '0;
      end else begin
        phase_cnt = bump(phase_cnt);
      end
    end
    if (ranger_phase == uer_pkg::PhTrigHigh) begin
      if (phase_cnt >= trig_len) begin
        ranger_phase = uer_pkg::PhWaitRise;
        phase_cnt    = '0;
      end else begin
        phase_cnt = bump(phase_cnt);
        r.trigger = 1'b1;
      end
    end
    // The tick that ends the trigger pulse already samples the echo
    if (ranger_phase == uer_pkg::PhWaitRise && !r.trigger) begin
      if (echo) begin
        ranger_phase = uer_pkg::PhWaitFall;
        phase_cnt    = '0;
        echo_cnt     = CountBits'(1);
      end else begin
        phase_cnt = bump(phase_cnt);
        if (phase_cnt >= ranger_cfg.rise_to) begin
          ranger_phase = uer_pkg::PhIdle;
          r.done       = 1'b1;
          r.status     = uer_pkg::StRiseTo;
        end
      end
    end else if (ranger_phase == uer_pkg::PhWaitFall) begin
      if (echo) begin
        if (echo_cnt != '1) echo_cnt = echo_cnt + 1'b1;
        phase_cnt = bump(phase_cnt);
        if (phase_cnt >= ranger_cfg.fall_to) begin
          ranger_phase = uer_pkg::PhIdle;
          r.done       = 1'b1;
          r.status     = uer_pkg::StFallTo;
        end
      end else begin
        ranger_phase = uer_pkg::PhIdle;
        r.done       = 1'b1;
        r.status     = uer_pkg::StOk;
        product      = echo_cnt * ranger_cfg.scale;
        dist_full    = product >> uer_pkg::FracW;
        r.distance   = ((dist_full >> uer_pkg::DistW) != '0) ? '1
                                                            : dist_full[uer_pkg::DistW-1:0];
        r.pulse      = ((echo_cnt >> uer_pkg::PulseW) != '0) ? '1
                                                             : echo_cnt[uer_pkg::PulseW-1:0];
      end
    end
    r.busy = (ranger_phase != uer_pkg::PhIdle);
    return r;
  endfunction

  // Offer one tick, wait for its transfer and log the predicted reading
  task automatic send_tick(input logic start_req, input logic echo);
    int unsigned gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap != 0) begin
      tick_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_if.valid     = 1'b1;
    tick_if.start_req = start_req;
    tick_if.echo      = echo;
    do @(posedge clk_i); while (tick_if.ready !== 1'b1);
    pending_readings.push_back(ranger_step(start_req, echo));
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Finish any open measurement, then wait until every reading is back
  task automatic settle();
    while (ranger_phase != uer_pkg::PhIdle) begin
      send_tick(1'b0, ranger_phase == uer_pkg::PhWaitRise);
    end
    tick_if.valid = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input uer_pkg::cfg_idx_e idx, input logic [uer_pkg::CfgW-1:0] data);
    settle();
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    case (idx)
      uer_pkg::CfgPreLow:   ranger_cfg.pre_low   = data[uer_pkg::PreW-1:0];
      uer_pkg::CfgTrigHigh: ranger_cfg.trig_high = data[uer_pkg::HighW-1:0];
      uer_pkg::CfgRiseTo:   ranger_cfg.rise_to   = data[uer_pkg::TimeW-1:0];
      uer_pkg::CfgFallTo:   ranger_cfg.fall_to   = data[uer_pkg::TimeW-1:0];
      uer_pkg::CfgScale:    ranger_cfg.scale     = data[uer_pkg::ScaleW-1:0];
      default: ;
    endcase
  endtask

  // One measurement: start, ride out the trigger, let the echo rise after
  // rise_delay low ticks and hold it for extra_high further ticks
  task automatic run_measurement(input int unsigned rise_delay, input int unsigned extra_high,
                                 input int unsigned start_pct, input bit early_echo);
    int unsigned low_seen;
    int unsigned high_seen;
    logic        start_bit;
    low_seen  = 0;
    high_seen = 0;
    send_tick(1'b1, early_echo);
    while (ranger_phase != uer_pkg::PhIdle) begin
      start_bit = ($urandom_range(0, 99) < start_pct);
      case (ranger_phase)
        uer_pkg::PhWaitRise: begin
          send_tick(start_bit, low_seen >= rise_delay);
          low_seen++;
        end
        uer_pkg::PhWaitFall: begin
          send_tick(start_bit, high_seen < extra_high);
          high_seen++;
        end
        default: send_tick(start_bit, early_echo || $urandom_range(0, 3) == 0);
      endcase
    end
  endtask

  task automatic set_timing(input logic [uer_pkg::CfgW-1:0] pre,
                            input logic [uer_pkg::CfgW-1:0] trig);
    write_reg(uer_pkg::CfgPreLow, pre);
    write_reg(uer_pkg::CfgTrigHigh, trig);
  endtask

  task automatic set_timeouts(input logic [uer_pkg::CfgW-1:0] rise,
                              input logic [uer_pkg::CfgW-1:0] fall);
    write_reg(uer_pkg::CfgRiseTo, rise);
    write_reg(uer_pkg::CfgFallTo, fall);
  endtask

  // Register defaults, idle ticks and an echo seen on the trigger-end tick
  task automatic test_reset_defaults();
    idling_on = 1'b0;
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    run_measurement(3, 12, 0, 1'b0);
    run_measurement(0, 2, 0, 1'b1);
  endtask

  // Zero pretrigger, zero trigger length, the longest of both and junk above the register width
  task automatic test_trigger_timing();
    set_timing(24'd0, 24'd0);
    run_measurement(1, 3, 0, 1'b0);
    set_timing(24'd255, 24'd255);
    run_measurement(2, 1, 0, 1'b0);
    set_timing(24'hABCD00, 24'h123401);
    run_measurement(0, 0, 0, 1'b0);
    set_timing(24'd3, 24'd2);
  endtask

  // Both timeouts at zero, on their boundary and at full range
  task automatic test_timeouts();
    set_timeouts(24'd0, 24'd100);
    run_measurement(5, 2, 0, 1'b0);
    set_timeouts(24'd4, 24'd100);
    run_measurement(3, 2, 0, 1'b0);
    run_measurement(4, 2, 0, 1'b0);
    set_timeouts(24'hFFFFFF, 24'd0);
    run_measurement(2, 5, 0, 1'b0);
    set_timeouts(24'hFFFFFF, 24'd6);
    run_measurement(1, 5, 0, 1'b0);
    run_measurement(1, 6, 0, 1'b0);
    run_measurement(1, 20, 0, 1'b0);
    set_timeouts(24'd20, 24'hFFFFFF);
    run_measurement(1, 30, 0, 1'b0);
  endtask

  // Distance scale at zero and full range, with junk above the register width
  task automatic test_scale();
    write_reg(uer_pkg::CfgScale, 24'hFC0000);
    run_measurement(2, 40, 0, 1'b0);
    write_reg(uer_pkg::CfgScale, 24'hFFFFFF);
    run_measurement(2, 60, 0, 1'b0);
    run_measurement(0, 0, 0, 1'b0);
  endtask

  // Start requests on every tick of a measurement, the done tick included
  task automatic test_start_while_busy();
    idling_on = 1'b1;
    run_measurement(4, 8, 100, 1'b0);
    run_measurement(30, 3, 100, 1'b0);
    run_measurement(2, 40, 100, 1'b0);
  endtask

  // Hold the reading side off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    idling_on = 1'b0;
    hold_req  = 1'b1;
    run_measurement(2, 40, 20, 1'b0);
    run_measurement(25, 5, 20, 1'b0);
    settle();
  endtask

  // Random settings; mostly well-formed measurements, some noise ticks
  task automatic test_random();
    int unsigned first;
    for (int s = 0; s < RandomSettings; s++) begin
      idling_on = (s % 3 != 2);
      set_timing({16'($urandom), 8'($urandom_range(0, 6))},
                 {16'($urandom), 8'($urandom_range(0, 12))});
      set_timeouts(24'($urandom_range(0, 40)), 24'($urandom_range(0, 50)));
      write_reg(uer_pkg::CfgScale, {6'($urandom), 18'($urandom)});
      first = ticks_sent;
      while (ticks_sent - first < RandomTicks / RandomSettings) begin
        if ($urandom_range(0, 9) < 8) begin
          run_measurement($urandom_range(0, ranger_cfg.rise_to + 3),
                          $urandom_range(0, ranger_cfg.fall_to + 3),
                          ($urandom_range(0, 1) == 0) ? 0 : 30,
                          $urandom_range(0, 9) == 0);
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end
      end
    end
  endtask

  // Reading side: random stalls, a long hold when asked
  initial begin
    reading_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        reading_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idling_on && $urandom_range(0, 2) == 0) begin
        reading_if.ready = 1'b0;
        repeat (gap_len()) @(negedge clk_i);
      end else begin
        reading_if.ready = 1'b1;
      end
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Compare every reading transfer with the oldest prediction
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && reading_if.valid === 1'b1 && reading_if.ready === 1'b1) begin
      if (pending_readings.size() == 0) begin
        $error("reading transfer with no tick outstanding");
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        check_field("trigger", want.trigger, reading_if.trigger);
        check_field("busy_res", want.busy, reading_if.busy_res);
        check_field("done_res", want.done, reading_if.done_res);
        check_field("status", want.status, reading_if.status);
        check_field("pulse_ticks", want.pulse, reading_if.pulse_ticks);
        check_field("distance_centi_cm", want.distance, reading_if.distance_centi_cm);
      end
    end
  end

  initial begin
    #(WatchdogNs);
    $display("tb_ultrasonic_echo_ranger_top: errors");
    $finish;
  end

  initial begin
    cfg_we            = 1'b0;
    cfg_idx           = uer_pkg::CfgPreLow;
    cfg_wdata         = '0;
    tick_if.valid     = 1'b0;
    tick_if.start_req = 1'b0;
    tick_if.echo      = 1'b0;
    ranger_cfg        = '{pre_low: uer_pkg::PreRst, trig_high: uer_pkg::HighRst,
                          rise_to: uer_pkg::RiseRst, fall_to: uer_pkg::FallRst,
                          scale: uer_pkg::ScaleRst};
    ranger_phase      = uer_pkg::PhIdle;
    phase_cnt         = '0;
    echo_cnt          = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_trigger_timing();
    test_timeouts();
    test_scale();
    test_start_while_busy();
    test_backpressure();
    test_random();
    settle();

    if (mismatches == 0) begin
      $display("tb_ultrasonic_echo_ranger_top: clean");
    end else begin
      $display("tb_ultrasonic_echo_ranger_top: errors");
    end
    $finish;
  end

endmodule
